// File: rtl/ptt_pkg.sv
// Shared types and constants of the periodic timer table.
package ptt_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // table index
    localparam int CNT_W   = $clog2(SLOTS + 1);                 // count 0..SLOTS
    localparam int CMP_W   = 11;                                // holds SLOTS max
    localparam int TIME_W  = 32;
    localparam int SID_W   = 6;
    localparam int DATA_IN_W  = 72;
    localparam int DATA_OUT_W = 16;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_REGISTER = 2'd1,
        KIND_REMOVE   = 2'd2,
        KIND_DISPATCH = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [TIME_W-1:0]  period;
        logic [TIME_W-1:0]  first_delay;
        logic               has_callback;
        logic               start_pending;
        logic [SID_W-1:0]   slot;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [SID_W-1:0]   slot_id;
        logic               fired;
    } t_res;

endpackage

// File: rtl/ptt_engine.sv
// Timer table engine: slot flags, period/countdown memory, tick walk and dispatch scan.
module ptt_engine
    import ptt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_done,
    output t_res  o_res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TICK = 3'b010,
        S_DISP = 3'b100
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_scan;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_rd_v;
    logic [SLOT_W-1:0]   r_rd_idx;
    logic [SLOTS-1:0]    r_en;
    logic [SLOTS-1:0]    r_cb;
    logic [SLOTS-1:0]    r_pend;
    logic                r_done;
    t_res                r_res;

    // {reload, countdown} per slot
    logic [2*TIME_W-1:0] r_mem [SLOTS];
    logic [2*TIME_W-1:0] r_rd_data;

    logic                start;
    logic                full;
    logic                bad;
    logic [SLOT_W-1:0]   rm_idx;
    logic [SLOT_W-1:0]   new_idx;
    logic [SLOT_W-1:0]   d_idx;
    logic [TIME_W-1:0]   per;
    logic [TIME_W-1:0]   first;
    logic [TIME_W-1:0]   rd_reload;
    logic [TIME_W-1:0]   rd_cnt;
    logic                expire;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_wa;
    logic [2*TIME_W-1:0] mem_wd;

    assign o_ready = (r_state == S_IDLE) && !r_done;
    assign start   = i_start && o_ready;
    assign full    = (CMP_W'(r_used) >= CMP_W'(SLOTS));
    assign bad     = (CMP_W'(i_item.slot) >= CMP_W'(SLOTS));
    assign rm_idx  = SLOT_W'(i_item.slot);
    assign new_idx = r_used[SLOT_W-1:0];
    assign d_idx   = r_idx[SLOT_W-1:0];
    assign per     = (i_item.period == '0) ? TIME_W'(1) : i_item.period;
    assign first   = (i_item.first_delay == '0) ? per : i_item.first_delay;

    assign rd_reload = r_rd_data[2*TIME_W-1:TIME_W];
    assign rd_cnt    = r_rd_data[TIME_W-1:0];
    assign expire    = (rd_cnt == TIME_W'(1));

    // one write port: register append in idle, countdown write-back while ticking
    always_comb begin
        mem_we = 1'b0;
        mem_wa = new_idx;
        mem_wd = {per, first};
        if (r_state == S_TICK) begin
            mem_we = r_rd_v && r_en[r_rd_idx];
            mem_wa = r_rd_idx;
            mem_wd = {rd_reload, expire ? rd_reload : (rd_cnt - TIME_W'(1))};
        end else if (start && (i_item.kind == KIND_REGISTER) && !full) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[d_idx];
    end

    // r_done is low on entry to the tick and dispatch walks and only rises as they finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_scan  <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_rd_v  <= 1'b0;
            r_en    <= '0;
            r_cb    <= '0;
            r_pend  <= '0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_item.kind)
                            KIND_TICK: begin
                                r_res   <= '{status: ST_OK, slot_id: '0, fired: 1'b0};
                                r_idx   <= '0;
                                r_rd_v  <= 1'b0;
                                r_state <= S_TICK;
                            end
                            KIND_REGISTER: begin
                                r_done <= 1'b1;
                                if (full) begin
                                    r_res <= '{status: ST_FULL, slot_id: '0, fired: 1'b0};
                                end else begin
                                    r_en[new_idx]   <= 1'b1;
                                    r_cb[new_idx]   <= i_item.has_callback;
                                    r_pend[new_idx] <= i_item.start_pending;
                                    r_used          <= r_used + CNT_W'(1);
                                    r_res           <= '{status: ST_OK,
                                                         slot_id: SID_W'(r_used),
                                                         fired: 1'b0};
                                end
                            end
                            KIND_REMOVE: begin
                                r_done <= 1'b1;
                                if (bad) begin
                                    r_res <= '{status: ST_BAD, slot_id: '0, fired: 1'b0};
                                end else begin
                                    r_res          <= '{status: ST_OK, slot_id: '0, fired: 1'b0};
                                    r_en[rm_idx]   <= 1'b0;
                                    r_cb[rm_idx]   <= 1'b0;
                                    r_pend[rm_idx] <= 1'b0;
                                end
                            end
                            default: begin
                                if (r_used == '0) begin
                                    r_done <= 1'b1;
                                    r_res  <= '{status: ST_NONE, slot_id: '0, fired: 1'b0};
                                end else begin
                                    r_idx   <= (r_scan >= r_used) ? '0 : r_scan;
                                    r_cnt   <= '0;
                                    r_state <= S_DISP;
                                end
                            end
                        endcase
                    end else begin
                        r_done <= 1'b0;
                    end
                end
                S_TICK: begin
                    // read slot r_idx, write back the slot read just before it
                    if (r_rd_v && r_en[r_rd_idx] && expire) begin
                        r_pend[r_rd_idx] <= 1'b1;
                    end
                    if (r_idx < r_used) begin
                        r_rd_v   <= 1'b1;
                        r_rd_idx <= d_idx;
                        r_idx    <= r_idx + CNT_W'(1);
                    end else begin
                        r_rd_v <= 1'b0;
                        if (!r_rd_v) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DISP: begin
                    if (r_cb[d_idx] && r_pend[d_idx]) begin
                        r_pend[d_idx] <= 1'b0;
                        r_scan        <= r_idx + CNT_W'(1);
                        r_res         <= '{status: ST_OK, slot_id: SID_W'(r_idx), fired: 1'b1};
                        r_done        <= 1'b1;
                        r_state       <= S_IDLE;
                    end else if (r_cnt == r_used - CNT_W'(1)) begin
                        r_res   <= '{status: ST_NONE, slot_id: '0, fired: 1'b0};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_idx <= (r_idx + CNT_W'(1) == r_used) ? '0 : r_idx + CNT_W'(1);
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_used) <= CMP_W'(SLOTS))
        else $error("slot count beyond table size");
    a_scan_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= r_used)
        else $error("scan start beyond used slots");
    a_tick_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) && r_rd_v |-> CNT_W'(r_rd_idx) < r_used)
        else $error("tick write-back outside used slots");
    a_disp_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |-> (r_idx < r_used) && (r_cnt < r_used))
        else $error("dispatch scan outside used slots");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("two results for one word");
`endif

endmodule

// File: rtl/periodic_timer_table_dispatch_core.sv
// Periodic timer table top level: stream handshake, result register and skid stage.
// Operation: a tick walks the used slots, one read per slot; a dispatch scans up to
// used_slots slots, one slot flag test per cycle.
// Throughput: one word in flight; the next is accepted once the engine has posted its
// result and the skid stage is empty.
// Reset: i_rst_n synchronous, active low; clears slot count, flags and scan start.
module periodic_timer_table_dispatch_core
    import ptt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // period[31:0], first_delay[63:32], has_callback[64], start_pending[65], slot[71:66]
    input  logic [DATA_IN_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  logic [1:0]            i_s_tuser,
    // master side
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // status[1:0], slot_id[7:2], fired[8], zero[15:9]
    output logic [DATA_OUT_W-1:0] o_m_tdata
);

    t_item item;
    logic  eng_ready;
    logic  eng_done;
    t_res  eng_res;

    logic  r_o_valid;
    t_res  r_o_res;
    logic  r_hold_v;     // skid: result finished while output register is still full
    t_res  r_hold;
    logic  out_free;

    assign item.kind          = t_kind'(i_s_tuser);
    assign item.period        = i_s_tdata[31:0];
    assign item.first_delay   = i_s_tdata[63:32];
    assign item.has_callback  = i_s_tdata[64];
    assign item.start_pending = i_s_tdata[65];
    assign item.slot          = i_s_tdata[71:66];

    // accepting only with an empty skid stage guarantees room for the word's result
    assign o_s_tready = eng_ready && !r_hold_v;

    ptt_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_s_tvalid && o_s_tready),
        .i_item  (item),
        .o_ready (eng_ready),
        .o_done  (eng_done),
        .o_res   (eng_res)
    );

    assign out_free = !r_o_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_hold_v  <= 1'b0;
        end else if (out_free) begin
            if (r_hold_v) begin
                r_o_valid <= 1'b1;
                r_o_res   <= r_hold;
                r_hold_v  <= eng_done;
                r_hold    <= eng_res;
            end else if (eng_done) begin
                r_o_valid <= 1'b1;
                r_o_res   <= eng_res;
            end else begin
                r_o_valid <= 1'b0;
            end
        end else if (eng_done) begin
            r_hold_v <= 1'b1;
            r_hold   <= eng_res;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {7'b0, r_o_res.fired, r_o_res.slot_id, r_o_res.status};

endmodule

// File: tb/periodic_timer_table_dispatch_core_test.sv
// Self-checking test of the periodic timer table dispatch core.
`timescale 1ns / 1ps

module periodic_timer_table_dispatch_core_test
    import ptt_pkg::*;
();

    // Mirror of the timer table: predicts one result per accepted word and
    // checks each result word against the oldest prediction.
    class timer_dispatch_tracker;
        int unsigned          used_cnt;
        int unsigned          next_scan;
        bit                   slot_on[SLOTS];
        bit                   slot_cb[SLOTS];
        bit                   slot_pend[SLOTS];
        logic [TIME_W-1:0]    slot_reload[SLOTS];
        logic [TIME_W-1:0]    slot_remain[SLOTS];
        t_res                 awaited_results[$];
        int unsigned          fault_count;

        function new();
            used_cnt    = 0;
            next_scan   = 0;
            fault_count = 0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_on[i]   = 1'b0;
                slot_cb[i]   = 1'b0;
                slot_pend[i] = 1'b0;
            end
        endfunction

        function void report_fault(string what);
            fault_count++;
            if (fault_count <= 10)
                $display("%0t mismatch: %s", $realtime, what);
        endfunction

        // Apply one accepted word to the table and queue the answer it must give.
        function void note_item(t_kind kind, logic [DATA_IN_W-1:0] data);
            logic [TIME_W-1:0] per;
            logic [TIME_W-1:0] first;
            logic [SID_W-1:0]  slot;
            t_res              res;
            int unsigned       idx;
            bit                found;
            per   = data[31:0];
            first = data[63:32];
            slot  = data[71:66];
            res.status  = ST_OK;
            res.slot_id = '0;
            res.fired   = 1'b0;
            found = 1'b0;
            case (kind)
                KIND_TICK: begin
                    for (int i = 0; i < used_cnt; i++) begin
                        if (slot_on[i]) begin
                            slot_remain[i] = slot_remain[i] - 1;
                            if (slot_remain[i] == '0) begin
                                slot_remain[i] = slot_reload[i];
                                slot_pend[i]   = 1'b1;
                            end
                        end
                    end
                end
                KIND_REGISTER: begin
                    if (used_cnt >= SLOTS) begin
                        res.status = ST_FULL;
                    end else begin
                        if (per == '0)
                            per = 1;
                        if (first == '0)
                            first = per;
                        slot_reload[used_cnt] = per;
                        slot_remain[used_cnt] = first;
                        slot_on[used_cnt]     = 1'b1;
                        slot_cb[used_cnt]     = data[64];
                        slot_pend[used_cnt]   = data[65];
                        res.slot_id = SID_W'(used_cnt);
                        used_cnt++;
                    end
                end
                KIND_REMOVE: begin
                    // slot field is 6 bits wide, so it always lands inside the table
                    if (slot >= SLOTS) begin
                        res.status = ST_BAD;
                    end else begin
                        slot_on[slot]   = 1'b0;
                        slot_cb[slot]   = 1'b0;
                        slot_pend[slot] = 1'b0;
                    end
                end
                default: begin
                    // round robin from just past the slot that fired last
                    res.status = ST_NONE;
                    for (int n = 0; n < used_cnt && !found; n++) begin
                        idx = (next_scan + n) % used_cnt;
                        if (slot_cb[idx] && slot_pend[idx]) begin
                            slot_pend[idx] = 1'b0;
                            next_scan      = idx + 1;
                            res.status     = ST_OK;
                            res.slot_id    = SID_W'(idx);
                            res.fired      = 1'b1;
                            found          = 1'b1;
                        end
                    end
                end
            endcase
            awaited_results.push_back(res);
        endfunction

        function void check_result(logic [DATA_OUT_W-1:0] word);
            t_res want;
            if (awaited_results.size() == 0) begin
                report_fault($sformatf("result word %h with nothing outstanding", word));
                return;
            end
            want = awaited_results.pop_front();
            if (word[1:0] !== want.status || word[7:2] !== want.slot_id
                    || word[8] !== want.fired)
                report_fault($sformatf(
                    "expected status %0d slot %0d fired %0d, got status %0d slot %0d fired %0d",
                    want.status, want.slot_id, want.fired, word[1:0], word[7:2], word[8]));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [DATA_IN_W-1:0]  i_s_tdata;      // period, first_delay, has_callback, start_pending, slot
    logic [1:0]            i_s_tuser;      // kind
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [DATA_OUT_W-1:0] o_m_tdata;      // status, slot_id, fired, zero pad

    timer_dispatch_tracker tracker = new();

    int unsigned burst_left = 0;

    periodic_timer_table_dispatch_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Both handshakes are sampled on the edge, before any of this edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            tracker.note_item(t_kind'(i_s_tuser), i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_result(o_m_tdata);
    end

    // Offer one word and hold it until taken; between bursts usually drop valid for a random gap.
    task automatic send_word(input t_kind kind, input logic [TIME_W-1:0] per,
                             input logic [TIME_W-1:0] first, input bit cb, input bit pend,
                             input logic [SID_W-1:0] slot);
        int unsigned gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {slot, pend, cb, first, per};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (burst_left == 0) begin
            // about a third of bursts run straight into the next one
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
    endtask

    // Random word: ticks and dispatches dominate, registers fill the table about halfway
    // through, and unused fields carry noise that the block must ignore.
    task automatic send_random_word();
        int unsigned       pick;
        t_kind             kind;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] first;
        pick  = $urandom_range(0, 99);
        per   = $urandom;
        first = $urandom;
        if (pick < 45)
            kind = KIND_TICK;
        else if (pick < 52)
            kind = KIND_REGISTER;
        else if (pick < 57)
            kind = KIND_REMOVE;
        else
            kind = KIND_DISPATCH;
        if (kind == KIND_REGISTER) begin
            // short periods keep slots firing; zero and full-width values now and then
            pick = $urandom_range(0, 9);
            if (pick < 7)
                per = $urandom_range(1, 6);
            else if (pick == 7)
                per = $urandom_range(7, 40);
            else if (pick == 8)
                per = '0;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                first = '0;
            else if (pick < 8)
                first = $urandom_range(1, 8);
        end
        send_word(kind, per, first, $urandom_range(0, 3) != 0, $urandom_range(0, 9) < 3,
                  SID_W'($urandom_range(0, SLOTS - 1)));
    endtask

    // Receiver: a long hold-off right after reset fills the block while the sender keeps
    // offering, then segments of always-ready, random stalls and an occasional long hold.
    initial begin
        int unsigned seg_len;
        int unsigned stall_pct;
        int unsigned mode;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        for (int c = 0; c < 300; c++)
            @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 29);
            if (mode == 0) begin
                seg_len = $urandom_range(150, 400);
                i_m_tready <= 1'b0;
                for (int c = 0; c < seg_len; c++)
                    @(posedge i_clk);
            end else begin
                seg_len   = $urandom_range(20, 100);
                stall_pct = (mode < 10) ? 0 : $urandom_range(10, 80);
                for (int c = 0; c < seg_len; c++) begin
                    i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= KIND_TICK;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, zero and full-width fields, skip rules, removal
        send_word(KIND_DISPATCH, '1, '1, 1'b1, 1'b1, '1);          // nothing ready on empty table
        send_word(KIND_TICK, '0, '0, 1'b0, 1'b0, '0);              // tick with no slots
        send_word(KIND_REMOVE, '0, '0, 1'b0, 1'b0, 6'd63);         // slot never handed out
        send_word(KIND_REGISTER, '0, '0, 1'b1, 1'b0, '1);          // period 0 -> 1, delay -> period
        send_word(KIND_REGISTER, '1, '1, 1'b1, 1'b1, '0);          // full-width period and delay
        send_word(KIND_REGISTER, 32'd3, '0, 1'b0, 1'b1, '0);       // pending but no callback
        send_word(KIND_REGISTER, 32'd2, 32'd5, 1'b1, 1'b0, '0);
        send_word(KIND_DISPATCH, '0, '0, 1'b0, 1'b0, '0);          // picks the pending slot 1
        send_word(KIND_DISPATCH, '0, '0, 1'b0, 1'b0, '0);          // no callback slot is skipped
        send_word(KIND_TICK, '1, '1, 1'b1, 1'b1, '1);              // slot 0 reaches zero
        send_word(KIND_DISPATCH, '0, '0, 1'b0, 1'b0, '0);          // wraps around to slot 0
        for (int i = 0; i < 5; i++)
            send_word(KIND_TICK, '0, '0, 1'b0, 1'b0, '0);
        send_word(KIND_DISPATCH, '0, '0, 1'b0, 1'b0, '0);
        send_word(KIND_REMOVE, '1, '1, 1'b1, 1'b1, 6'd0);          // disable a live slot
        send_word(KIND_TICK, '0, '0, 1'b0, 1'b0, '0);
        send_word(KIND_DISPATCH, '0, '0, 1'b0, 1'b0, '0);
        send_word(KIND_REGISTER, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1, 6'h2A);
        send_word(KIND_REMOVE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1, 6'd2);
        send_word(KIND_DISPATCH, '0, '0, 1'b0, 1'b0, '0);
        send_word(KIND_DISPATCH, '0, '0, 1'b0, 1'b0, '0);
        send_word(KIND_DISPATCH, '0, '0, 1'b0, 1'b0, '0);

        for (int i = 0; i < 1800; i++)
            send_random_word();
        i_s_tvalid <= 1'b0;

        while (tracker.awaited_results.size() != 0)
            @(posedge i_clk);
        // a tick on a full table is the longest the engine stays busy
        repeat (SLOTS + 20) @(posedge i_clk);

        if (tracker.fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ptt_pkg.sv
rtl/ptt_engine.sv
rtl/periodic_timer_table_dispatch_core.sv
tb/periodic_timer_table_dispatch_core_test.sv
